// ===== rtl/rne_pkg.sv =====
// Package for the Roman numeral encoder: letter codes, divisor constants,
// microcode control word, sequencer/datapath status and the microprogram ROM.
// No dependencies.
package rne_pkg;

  // Default thousands limit (valid input is 1 .. MAX_THOUSANDS*1000+999)
  localparam int MAX_THOUSANDS_DEF = 3;

  localparam int NUM_W  = 12;  // input number width
  localparam int SYM_W  = 7;   // ASCII symbol width
  localparam int DIG_W  = 4;   // one decimal digit
  localparam int STEP_W = 3;   // microprogram address width

  // ASCII letters
  localparam logic [SYM_W-1:0] CH_NONE = 7'h00;
  localparam logic [SYM_W-1:0] CH_M    = 7'h4D;
  localparam logic [SYM_W-1:0] CH_D    = 7'h44;
  localparam logic [SYM_W-1:0] CH_C    = 7'h43;
  localparam logic [SYM_W-1:0] CH_L    = 7'h4C;
  localparam logic [SYM_W-1:0] CH_X    = 7'h58;
  localparam logic [SYM_W-1:0] CH_V    = 7'h56;
  localparam logic [SYM_W-1:0] CH_I    = 7'h49;

  // Divisors for digit extraction
  localparam logic [NUM_W-1:0] K1000 = 12'd1000;
  localparam logic [NUM_W-1:0] K100  = 12'd100;
  localparam logic [NUM_W-1:0] K10   = 12'd10;

  // Digit positions
  localparam logic [1:0] POS_TH = 2'd0;
  localparam logic [1:0] POS_HU = 2'd1;
  localparam logic [1:0] POS_TE = 2'd2;
  localparam logic [1:0] POS_ON = 2'd3;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses
  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_D1000 = 3'd1;
  localparam step_t STEP_D100  = 3'd2;
  localparam step_t STEP_D10   = 3'd3;
  localparam step_t STEP_ONES  = 3'd4;
  localparam step_t STEP_EMIT  = 3'd5;
  localparam step_t STEP_ERR   = 3'd6;

  typedef enum logic [2:0] {
    OP_WAIT,  // take a word; jump on bad number, else advance
    OP_DIV,   // subtract divisor while it fits, then store quotient digit
    OP_ONES,  // remainder is the ones digit
    OP_EMIT,  // send one letter per cycle while the output is free; jump when last is sent
    OP_ERR    // send the error word; jump when sent
  } op_t;

  typedef enum logic [1:0] {
    KS_1000,
    KS_100,
    KS_10
  } ksel_t;

  typedef struct packed {
    op_t        op;
    ksel_t      ksel;
    logic [1:0] dpos;
    step_t      jmp;
  } cw_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic in_fire;
    logic num_bad;
    logic rem_ge;
    logic emit_done;
    logic err_sent;
  } stat_t;

  // Microprogram ROM
  function automatic cw_t ucode(step_t a);
    cw_t w;
    w = '{op: OP_WAIT, ksel: KS_1000, dpos: POS_TH, jmp: STEP_WAIT};
    case (a)
      STEP_WAIT:  w = '{op: OP_WAIT, ksel: KS_1000, dpos: POS_TH, jmp: STEP_ERR};
      STEP_D1000: w = '{op: OP_DIV,  ksel: KS_1000, dpos: POS_TH, jmp: STEP_WAIT};
      STEP_D100:  w = '{op: OP_DIV,  ksel: KS_100,  dpos: POS_HU, jmp: STEP_WAIT};
      STEP_D10:   w = '{op: OP_DIV,  ksel: KS_10,   dpos: POS_TE, jmp: STEP_WAIT};
      STEP_ONES:  w = '{op: OP_ONES, ksel: KS_10,   dpos: POS_ON, jmp: STEP_WAIT};
      STEP_EMIT:  w = '{op: OP_EMIT, ksel: KS_10,   dpos: POS_ON, jmp: STEP_WAIT};
      STEP_ERR:   w = '{op: OP_ERR,  ksel: KS_10,   dpos: POS_ON, jmp: STEP_WAIT};
      default:    w = '{op: OP_WAIT, ksel: KS_1000, dpos: POS_TH, jmp: STEP_ERR};
    endcase
    return w;
  endfunction

  // Letters of each decade
  function automatic logic [SYM_W-1:0] letter_one(logic [1:0] p);
    logic [SYM_W-1:0] c;
    unique case (p)
      POS_TH:  c = CH_M;
      POS_HU:  c = CH_C;
      POS_TE:  c = CH_X;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  function automatic logic [SYM_W-1:0] letter_five(logic [1:0] p);
    logic [SYM_W-1:0] c;
    unique case (p)
      POS_HU:  c = CH_D;
      POS_TE:  c = CH_L;
      POS_ON:  c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [SYM_W-1:0] letter_ten(logic [1:0] p);
    logic [SYM_W-1:0] c;
    unique case (p)
      POS_HU:  c = CH_M;
      POS_TE:  c = CH_C;
      POS_ON:  c = CH_X;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // Number of letters for digit d at position p
  function automatic logic [DIG_W-1:0] digit_len(logic [1:0] p, logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] n;
    if (p == POS_TH)                  n = d;
    else if (d == 4'd9 || d == 4'd4)  n = 4'd2;
    else if (d >= 4'd5)               n = d - 4'd4;
    else                              n = d;
    return n;
  endfunction

  // Letter s of digit d at position p (subtractive rule below thousands)
  function automatic logic [SYM_W-1:0] digit_char(logic [1:0] p, logic [DIG_W-1:0] d,
                                                 logic [2:0] s);
    logic [SYM_W-1:0] c;
    if (p == POS_TH)      c = CH_M;
    else if (d == 4'd9)   c = (s == 3'd0) ? letter_one(p)  : letter_ten(p);
    else if (d == 4'd4)   c = (s == 3'd0) ? letter_one(p)  : letter_five(p);
    else if (d >= 4'd5)   c = (s == 3'd0) ? letter_five(p) : letter_one(p);
    else                  c = letter_one(p);
    return c;
  endfunction

endpackage

// ===== rtl/roman_numeral_encoder.sv =====
// Roman numeral encoder top level: microcode sequencer plus datapath.
// Depends on rne_pkg, rne_sequencer and rne_datapath.
//
//  channel  direction  handshake        word contents
//  in       input      valid / stall    number[11:0]
//  out      output     valid / stall    symbol[6:0], last, error
//
// One number is in flight at a time; in_stall is low only in the wait step.
// Each number passes the wait step, digit extraction (thousands, hundreds and
// tens, one subtraction of 1000/100/10 per cycle), the ones step and letter
// emission, in which zero digits before the last letter are skipped.
// A rejected number goes from the wait step to the error step instead.
// The output register holds one word; out_stall pauses letter emission.
// rst_n is synchronous, active low, and returns the sequencer to the wait step.
module roman_numeral_encoder #(
  parameter int MAX_THOUSANDS = rne_pkg::MAX_THOUSANDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rne_pkg::NUM_W-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rne_pkg::SYM_W-1:0] out_symbol,
  output logic                      out_last,
  output logic                      out_error
);

  rne_pkg::cw_t   cw;
  rne_pkg::stat_t st;

  assign in_stall = (cw.op != rne_pkg::OP_WAIT);

  rne_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw)
  );

  rne_datapath #(
    .MAX_THOUSANDS (MAX_THOUSANDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .st         (st),
    .in_valid   (in_valid),
    .in_number  (in_number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_error  (out_error)
  );

endmodule

// ===== rtl/rne_sequencer.sv =====
// Microcode sequencer: step counter, ROM lookup and jump logic.
// Depends on rne_pkg (control word, status, microprogram).
module rne_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  input  rne_pkg::stat_t st,
  output rne_pkg::cw_t   cw
);

  rne_pkg::step_t step_r, step_nxt;

  // ROM read
  assign cw = rne_pkg::ucode(step_r);

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rne_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // next step: hold, advance or jump depending on op and status
  always_comb begin
    step_nxt = step_r;
    unique case (cw.op)
      rne_pkg::OP_WAIT: begin
        if (st.in_fire) step_nxt = st.num_bad ? cw.jmp : rne_pkg::step_t'(step_r + 3'd1);
      end
      rne_pkg::OP_DIV: begin
        if (!st.rem_ge) step_nxt = rne_pkg::step_t'(step_r + 3'd1);
      end
      rne_pkg::OP_ONES: begin
        step_nxt = rne_pkg::step_t'(step_r + 3'd1);
      end
      rne_pkg::OP_EMIT: begin
        if (st.emit_done) step_nxt = cw.jmp;
      end
      rne_pkg::OP_ERR: begin
        if (st.err_sent) step_nxt = cw.jmp;
      end
      default: begin
        step_nxt = rne_pkg::STEP_WAIT;
      end
    endcase
  end

endmodule

// ===== rtl/rne_datapath.sv =====
// Datapath: remainder/quotient registers, digit registers, letter selection
// and the output register. Driven by the control word; depends on rne_pkg.
module rne_datapath #(
  parameter int MAX_THOUSANDS = rne_pkg::MAX_THOUSANDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rne_pkg::cw_t                  cw,
  output rne_pkg::stat_t                st,
  input  logic                          in_valid,
  input  logic [rne_pkg::NUM_W-1:0]     in_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rne_pkg::SYM_W-1:0]     out_symbol,
  output logic                          out_last,
  output logic                          out_error
);

  localparam int LIMIT = MAX_THOUSANDS * 1000 + 999;
  localparam int LIM_W = $clog2(LIMIT + 1);
  localparam int CMP_W = (LIM_W > rne_pkg::NUM_W) ? LIM_W : rne_pkg::NUM_W;
  localparam logic [CMP_W-1:0] LIMIT_V = CMP_W'(LIMIT);

  logic [rne_pkg::NUM_W-1:0] rem_r;
  logic [rne_pkg::DIG_W-1:0] q_r;
  logic [rne_pkg::DIG_W-1:0] digit_r [4];
  logic [1:0]                pos_r;
  logic [2:0]                s_r;

  logic                      out_valid_r;
  logic [rne_pkg::SYM_W-1:0] out_symbol_r;
  logic                      out_last_r;
  logic                      out_error_r;

  logic [rne_pkg::NUM_W-1:0] kval;
  logic                      out_free;
  logic [rne_pkg::DIG_W-1:0] cur_d;
  logic [rne_pkg::DIG_W-1:0] cur_len;
  logic                      dig_end;
  logic                      later_zero;
  logic                      emit_go;
  logic                      emit_last;
  logic                      err_go;

  // input check
  assign st.in_fire = in_valid && (cw.op == rne_pkg::OP_WAIT);
  assign st.num_bad = (in_number == '0) ||
                      (CMP_W'(in_number) > LIMIT_V);

  // divisor select and compare
  always_comb begin
    unique case (cw.ksel)
      rne_pkg::KS_1000: kval = rne_pkg::K1000;
      rne_pkg::KS_100:  kval = rne_pkg::K100;
      default:          kval = rne_pkg::K10;
    endcase
  end
  assign st.rem_ge = (rem_r >= kval);

  // letter generation for the current digit
  assign out_free = !out_valid_r || !out_stall;
  assign cur_d    = digit_r[pos_r];
  assign cur_len  = rne_pkg::digit_len(pos_r, cur_d);
  assign dig_end  = ({1'b0, s_r} == (cur_len - 4'd1));

  always_comb begin
    unique case (pos_r)
      rne_pkg::POS_TH: later_zero = (digit_r[1] == '0) && (digit_r[2] == '0) &&
                                    (digit_r[3] == '0);
      rne_pkg::POS_HU: later_zero = (digit_r[2] == '0) && (digit_r[3] == '0);
      rne_pkg::POS_TE: later_zero = (digit_r[3] == '0);
      default:         later_zero = 1'b1;
    endcase
  end

  assign emit_go   = (cw.op == rne_pkg::OP_EMIT) && (cur_len != '0) && out_free;
  assign emit_last = dig_end && later_zero;
  assign err_go    = (cw.op == rne_pkg::OP_ERR) && out_free;

  assign st.emit_done = emit_go && emit_last;
  assign st.err_sent  = err_go;

  // digit extraction by repeated subtraction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
      for (int i = 0; i < 4; i++) digit_r[i] <= '0;
    end else begin
      case (cw.op)
        rne_pkg::OP_WAIT: begin
          if (st.in_fire) begin
            rem_r <= in_number;
            q_r   <= '0;
          end
        end
        rne_pkg::OP_DIV: begin
          if (st.rem_ge) begin
            rem_r <= rem_r - kval;
            q_r   <= q_r + 4'd1;
          end else begin
            digit_r[cw.dpos] <= q_r;
            q_r              <= '0;
          end
        end
        rne_pkg::OP_ONES: begin
          digit_r[rne_pkg::POS_ON] <= rem_r[rne_pkg::DIG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // walk of digit position and letter index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= rne_pkg::POS_TH;
      s_r   <= '0;
    end else if (cw.op == rne_pkg::OP_EMIT) begin
      if (cur_len == '0) begin
        pos_r <= pos_r + 2'd1;
        s_r   <= '0;
      end else if (emit_go) begin
        if (emit_last) begin
          pos_r <= rne_pkg::POS_TH;
          s_r   <= '0;
        end else if (dig_end) begin
          pos_r <= pos_r + 2'd1;
          s_r   <= '0;
        end else begin
          s_r <= s_r + 3'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go || err_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_symbol_r <= rne_pkg::digit_char(pos_r, cur_d, s_r);
      out_last_r   <= emit_last;
      out_error_r  <= 1'b0;
    end else if (err_go) begin
      out_symbol_r <= rne_pkg::CH_NONE;
      out_last_r   <= 1'b1;
      out_error_r  <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_error  = out_error_r;

endmodule

// ===== rtl/rne_checker.sv =====
// Port-level checker for the Roman numeral encoder, bound to the top level.
// Depends on rne_pkg (letter codes) and roman_numeral_encoder.
module rne_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [rne_pkg::SYM_W-1:0] out_symbol,
  input logic                      out_last,
  input logic                      out_error
);

  // an error word is a lone, terminal word with no letter
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_symbol == rne_pkg::CH_NONE))
    else $error("error word not last or carries a letter");

  // a good word always carries a numeral letter
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |->
      (out_symbol == rne_pkg::CH_M) || (out_symbol == rne_pkg::CH_D) ||
      (out_symbol == rne_pkg::CH_C) || (out_symbol == rne_pkg::CH_L) ||
      (out_symbol == rne_pkg::CH_X) || (out_symbol == rne_pkg::CH_V) ||
      (out_symbol == rne_pkg::CH_I))
    else $error("output symbol is not a numeral letter");

  // the block is busy right after taking a number
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) &&
      $stable(out_last) && $stable(out_error))
    else $error("stalled output word changed");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_symbol (out_symbol),
  .out_last   (out_last),
  .out_error  (out_error)
);
